>>> src/sir_pkg.sv
// ============================================================================
// sir_pkg
// Shared types and constants for the signed integer remainder pipeline.
// ============================================================================
`default_nettype none

package sir_pkg;

    // Operand and result width of the long form.
    localparam int DATA_W = 64;
    // Operand width of the int form.
    localparam int HALF_W = 32;

    // Width selector codes carried on the input user field.
    localparam logic CMD_INT  = 1'b0;
    localparam logic CMD_LONG = 1'b1;

    // Everything one beat carries down the row of divider cells.
    typedef struct packed {
        logic [DATA_W-1:0] rem;     // partial remainder magnitude
        logic [DATA_W-1:0] quo;     // dividend magnitude, shifted out MSB first
        logic [DATA_W-1:0] dvs;     // divisor magnitude
        logic              neg;     // dividend was negative
        logic              dbz;     // divisor was zero
    } stage_t;

endpackage

`default_nettype wire

>>> src/sir_prep.sv
// ============================================================================
// sir_prep
// Operand conditioning: width selection, sign extension, magnitudes and
// zero-divisor detection, registered into the head of the cell row.
// ============================================================================
`default_nettype none

module sir_prep (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic                           command,
    input  wire logic [sir_pkg::DATA_W-1:0]     dividend,
    input  wire logic [sir_pkg::DATA_W-1:0]     divisor,
    output      logic                           out_valid,
    output      sir_pkg::stage_t                out_data
);

    logic                       valid_reg;
    sir_pkg::stage_t            data_reg;
    sir_pkg::stage_t            data_next;
    logic [sir_pkg::DATA_W-1:0] a_ext;
    logic [sir_pkg::DATA_W-1:0] b_ext;

    always_comb
    begin
        if (command == sir_pkg::CMD_LONG)
        begin
            a_ext = dividend;
            b_ext = divisor;
        end
        else
        begin
            a_ext = {{(sir_pkg::DATA_W-sir_pkg::HALF_W){dividend[sir_pkg::HALF_W-1]}},
                     dividend[sir_pkg::HALF_W-1:0]};
            b_ext = {{(sir_pkg::DATA_W-sir_pkg::HALF_W){divisor[sir_pkg::HALF_W-1]}},
                     divisor[sir_pkg::HALF_W-1:0]};
        end
        data_next.rem = '0;
        data_next.neg = a_ext[sir_pkg::DATA_W-1];
        data_next.quo = a_ext[sir_pkg::DATA_W-1] ? ('0 - a_ext) : a_ext;
        data_next.dvs = b_ext[sir_pkg::DATA_W-1] ? ('0 - b_ext) : b_ext;
        data_next.dbz = (b_ext == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> src/sir_cell.sv
// ============================================================================
// sir_cell
// One restoring division step: shift in one dividend bit, trial-subtract
// the divisor and keep the difference when it does not go negative.
// ============================================================================
`default_nettype none

module sir_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sir_pkg::stage_t    in_data,
    output      logic               out_valid,
    output      sir_pkg::stage_t    out_data
);

    logic                       valid_reg;
    sir_pkg::stage_t            data_reg;
    sir_pkg::stage_t            data_next;
    logic [sir_pkg::DATA_W:0]   shifted;
    logic [sir_pkg::DATA_W:0]   diff;

    always_comb
    begin
        shifted = {in_data.rem, in_data.quo[sir_pkg::DATA_W-1]};
        diff    = shifted - {1'b0, in_data.dvs};
        data_next     = in_data;
        data_next.quo = {in_data.quo[sir_pkg::DATA_W-2:0], 1'b0};
        // The remainder stays below the divisor, so it always fits the width.
        data_next.rem = diff[sir_pkg::DATA_W] ? shifted[sir_pkg::DATA_W-1:0]
                                              : diff[sir_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> src/sir_out.sv
// ============================================================================
// sir_out
// Result sign fix-up and zero-divisor masking, followed by an output
// register with a skid stage that lets the cell row run one more beat.
// ============================================================================
`default_nettype none

module sir_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire sir_pkg::stage_t                in_data,
    output      logic                           en,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output      logic [sir_pkg::DATA_W-1:0]     m_axis_tdata,
    output      logic                           m_axis_tuser
);

    logic                       out_valid_reg;
    logic [sir_pkg::DATA_W-1:0] out_rem_reg;
    logic                       out_dbz_reg;
    logic                       skid_valid_reg;
    logic [sir_pkg::DATA_W-1:0] skid_rem_reg;
    logic                       skid_dbz_reg;
    logic [sir_pkg::DATA_W-1:0] rem_final;
    logic                       arriving;
    logic                       take;

    // A negative dividend gives a negative remainder; int results already
    // lie in the 32-bit range, so the 64-bit form is their sign extension.
    always_comb
    begin
        if (in_data.dbz)
        begin
            rem_final = '0;
        end
        else if (in_data.neg)
        begin
            rem_final = '0 - in_data.rem;
        end
        else
        begin
            rem_final = in_data.rem;
        end
    end

    assign en       = !skid_valid_reg;
    assign arriving = en && in_valid;
    assign take     = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (arriving)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arriving)
        begin
            if (!out_valid_reg || take)
            begin
                out_rem_reg <= rem_final;
                out_dbz_reg <= in_data.dbz;
            end
            else
            begin
                skid_rem_reg <= rem_final;
                skid_dbz_reg <= in_data.dbz;
            end
        end
        else if (take)
        begin
            out_rem_reg <= skid_rem_reg;
            out_dbz_reg <= skid_dbz_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_rem_reg;
    assign m_axis_tuser  = out_dbz_reg;

endmodule

`default_nettype wire

>>> src/signed_integer_remainder.sv
// ============================================================================
// signed_integer_remainder
// Pipelined signed truncating remainder for 32-bit and 64-bit operands.
// ============================================================================
//
//  Channel   Dir   tdata                           tuser
//  s_axis    in    [63:0] dividend, [127:64] divisor  [0] command (1 = long)
//  m_axis    out   [63:0] remainder                [0] divide_by_zero
//
// One beat is accepted per cycle while the skid register is empty. Each beat passes
// through one conditioning stage, one cell per dividend bit (64 cells, one
// restoring subtract each) and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// When the output is stalled the row moves one more beat into a skid
// register and then holds, with s_axis_tready low until the skid drains.
//
// The remainder takes the dividend's sign. A zero divisor gives remainder 0
// with divide_by_zero set. The most negative value modulo minus one falls
// out of the magnitude division as 0. In int mode the upper halves of both
// operands are ignored and the result is sign-extended.
// ============================================================================
`default_nettype none

module signed_integer_remainder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output      logic           s_axis_tready,
    input  wire logic [127:0]   s_axis_tdata,   // [63:0] dividend, [127:64] divisor
    input  wire logic           s_axis_tuser,   // [0] command
    output      logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output      logic [63:0]    m_axis_tdata,   // [63:0] remainder
    output      logic           m_axis_tuser    // [0] divide_by_zero
);

    localparam int N_CELLS = sir_pkg::DATA_W;

    logic               en;
    logic               valid_chain [N_CELLS+1];
    sir_pkg::stage_t    data_chain  [N_CELLS+1];

    // The whole row advances together; it only stops while the skid is full.
    assign s_axis_tready = en;

    sir_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .command   (s_axis_tuser),
        .dividend  (s_axis_tdata[sir_pkg::DATA_W-1:0]),
        .divisor   (s_axis_tdata[2*sir_pkg::DATA_W-1:sir_pkg::DATA_W]),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    // Cell k brings in dividend bit 63-k and decides quotient bit 63-k of
    // the magnitude division.
    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        sir_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[k]),
            .in_data   (data_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_data  (data_chain[k+1])
        );
    end

    sir_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_chain[N_CELLS]),
        .in_data       (data_chain[N_CELLS]),
        .en            (en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
